// ===== rtl/srec_pkg.sv =====
// Shared types, codes and constants for the S3 record encoder.
// Used by srec_ctrl, srec_dp and srecord_s3_encoder; no dependencies.
`default_nettype none

package srec_pkg;

   // Item opcodes
   localparam logic [1:0] OP_DATA   = 2'd0;
   localparam logic [1:0] OP_RANGE  = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;

   // Configuration register indexes
   localparam logic CSR_MAX_RECORD_BYTES = 1'b0;
   localparam logic CSR_ENTRY_FROM_FIRST = 1'b1;

   localparam int          CSR_DATA_WIDTH     = 5;
   localparam logic [4:0]  MAX_BYTES_RESET    = 5'd16;

   // Record text characters
   localparam logic [6:0] CHAR_S      = 7'h53;
   localparam logic [6:0] CHAR_KIND3  = 7'h33;
   localparam logic [6:0] CHAR_KIND7  = 7'h37;
   localparam logic [6:0] CHAR_NL     = 7'd10;
   localparam logic [7:0] COUNT_BASE  = 8'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_S,
      ST_KIND,
      ST_HI,
      ST_LO,
      ST_NL
   } state_type;

   typedef enum logic [2:0] {
      CH_S,
      CH_KIND,
      CH_HI,
      CH_LO,
      CH_NL
   } char_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic         load;
      logic         emit;
      char_sel_type sel;
      logic         next_byte;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic emit_req;
      logic csum_byte;
      logic out_free;
   } status_type;

   // Uppercase hex digit for one nibble
   function automatic logic [6:0] hex_digit(input logic [3:0] nib);
      logic [6:0] code;
      if (nib < 4'd10) begin
         code = 7'h30 + {3'b000, nib};
      end else begin
         code = 7'h37 + {3'b000, nib};
      end
      return code;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/srec_ctrl.sv =====
// Sequencing state machine of the S3 record encoder: item intake and the
// character order of each record. Depends on srec_pkg.
`default_nettype none

module srec_ctrl
   import srec_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire status_type status,
   output      cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      req_stall     = 1'b1;
      cmd.load      = 1'b0;
      cmd.emit      = 1'b0;
      cmd.sel       = CH_S;
      cmd.next_byte = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.emit_req) begin
                  state_in = ST_S;
               end
            end
         end
         ST_S: begin
            cmd.sel = CH_S;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_KIND;
            end
         end
         ST_KIND: begin
            cmd.sel = CH_KIND;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_HI;
            end
         end
         ST_HI: begin
            cmd.sel = CH_HI;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_LO;
            end
         end
         ST_LO: begin
            cmd.sel = CH_LO;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               // advance to the next byte, or close after the checksum
               if (status.csum_byte) begin
                  state_in = ST_NL;
               end else begin
                  cmd.next_byte = 1'b1;
                  state_in      = ST_HI;
               end
            end
         end
         ST_NL: begin
            cmd.sel = CH_NL;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/srec_dp.sv =====
// Datapath of the S3 record encoder: configuration, record buffer, address
// state, byte selection, checksum and output register. Depends on srec_pkg.
`default_nettype none

module srec_dp
   import srec_pkg::*;
#(
   parameter int MAX_RECORD_BYTES = 16
)(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write,
   input  wire logic                      csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_data,
   input  wire logic [1:0]                req_opcode,
   input  wire logic [7:0]                req_data_byte,
   input  wire logic                      req_range_first,
   input  wire logic                      req_range_last,
   input  wire logic [31:0]               req_start_address,
   input  wire logic                      rsp_stall,
   output      logic                      rsp_valid,
   output      logic [6:0]                rsp_ascii_char,
   output      logic                      rsp_line_end,
   input  wire cmd_type                   cmd,
   output      status_type                status
);

   localparam int FW = $clog2(MAX_RECORD_BYTES + 1);
   localparam int BW = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;
   localparam int IW = $clog2(MAX_RECORD_BYTES + 6);
   localparam logic [FW-1:0] MAX_FILL = FW'(MAX_RECORD_BYTES);
   localparam logic [IW-1:0] DATA_BASE = IW'(5);

   // Configuration and record state
   logic [4:0]    max_bytes_ff;
   logic          entry_first_ff;
   logic [FW-1:0] fill_ff, fill_in;
   logic [31:0]   record_addr_ff, record_addr_in;
   logic [31:0]   next_addr_ff, next_addr_in;
   logic [31:0]   entry_start_ff, entry_start_in;
   logic          entry_valid_ff, entry_valid_in;

   // Record being sent
   logic [7:0]    buffer_ff [MAX_RECORD_BYTES];
   logic          kind7_ff, kind7_in;
   logic [7:0]    count_ff, count_in;
   logic [31:0]   emit_addr_ff, emit_addr_in;
   logic [FW-1:0] emit_len_ff, emit_len_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [7:0]    sum_ff, sum_in;

   // Output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [6:0]    rsp_char_ff, rsp_char_in;
   logic          rsp_end_ff, rsp_end_in;

   logic [FW-1:0] limit;
   logic [FW-1:0] fill_base;
   logic [FW-1:0] fill_next;
   logic [31:0]   addr_base;
   logic          opens;
   logic          data_emit;
   logic [IW-1:0] data_idx;
   logic [7:0]    cur_byte;
   logic          emit_req;
   logic          csum_hit;
   logic          out_free;

   // Clamp the record length to 1..MAX_RECORD_BYTES
   always_comb begin
      if (max_bytes_ff == 5'd0) begin
         limit = FW'(1);
      end else if ({{FW{1'b0}}, max_bytes_ff} > {5'd0, MAX_FILL}) begin
         limit = MAX_FILL;
      end else begin
         limit = max_bytes_ff[FW-1:0] | {FW{1'b0}};
      end
   end

   // Item decode
   always_comb begin
      opens     = (req_opcode == OP_DATA) && req_range_first;
      fill_base = opens ? '0 : fill_ff;
      addr_base = opens ? req_start_address : next_addr_ff;
      fill_next = fill_base + FW'(1);
      data_emit = (fill_next >= limit) || req_range_last;
   end

   assign emit_req = ((req_opcode == OP_DATA) && data_emit) ||
                     (req_opcode == OP_FINISH);

   assign status = {emit_req, csum_hit, out_free};

   // State update on item load
   always_comb begin
      fill_in        = fill_ff;
      record_addr_in = record_addr_ff;
      next_addr_in   = next_addr_ff;
      entry_start_in = entry_start_ff;
      entry_valid_in = entry_valid_ff;
      kind7_in       = kind7_ff;
      count_in       = count_ff;
      emit_addr_in   = emit_addr_ff;
      emit_len_in    = emit_len_ff;
      if (cmd.load) begin
         case (req_opcode)
            OP_DATA: begin
               if (opens && !entry_valid_ff) begin
                  entry_start_in = req_start_address;
                  entry_valid_in = 1'b1;
               end
               if (fill_base == '0) begin
                  record_addr_in = addr_base;
               end
               next_addr_in = addr_base + 32'd1;
               fill_in      = data_emit ? '0 : fill_next;
               kind7_in     = 1'b0;
               count_in     = 8'(fill_next) + COUNT_BASE;
               emit_addr_in = (fill_base == '0) ? addr_base : record_addr_ff;
               emit_len_in  = fill_next;
            end
            OP_RANGE: begin
               fill_in      = '0;
               next_addr_in = req_start_address;
               if (!entry_valid_ff) begin
                  entry_start_in = req_start_address;
                  entry_valid_in = 1'b1;
               end
            end
            OP_FINISH: begin
               kind7_in       = 1'b1;
               count_in       = COUNT_BASE;
               emit_addr_in   = (entry_first_ff && entry_valid_ff) ? entry_start_ff : 32'd0;
               emit_len_in    = '0;
               fill_in        = '0;
               record_addr_in = 32'd0;
               next_addr_in   = 32'd0;
               entry_start_in = 32'd0;
               entry_valid_in = 1'b0;
            end
            default: begin
               // unused opcode: drop
            end
         endcase
      end
   end

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff   <= MAX_BYTES_RESET;
         entry_first_ff <= 1'b1;
         fill_ff        <= '0;
         record_addr_ff <= 32'd0;
         next_addr_ff   <= 32'd0;
         entry_start_ff <= 32'd0;
         entry_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_MAX_RECORD_BYTES: max_bytes_ff   <= csr_data;
               CSR_ENTRY_FROM_FIRST: entry_first_ff <= csr_data[0];
               default: begin
               end
            endcase
         end
         fill_ff        <= fill_in;
         record_addr_ff <= record_addr_in;
         next_addr_ff   <= next_addr_in;
         entry_start_ff <= entry_start_in;
         entry_valid_ff <= entry_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Record buffer write
   always_ff @(posedge clock) begin
      if (cmd.load && (req_opcode == OP_DATA)) begin
         buffer_ff[fill_base[BW-1:0]] <= req_data_byte;
      end
   end

   // Byte in turn: count, four address bytes, data, checksum
   always_comb begin
      data_idx = idx_ff - DATA_BASE;
      csum_hit = (idx_ff == (IW'(emit_len_ff) + DATA_BASE));
      case (idx_ff)
         IW'(0): cur_byte = count_ff;
         IW'(1): cur_byte = emit_addr_ff[31:24];
         IW'(2): cur_byte = emit_addr_ff[23:16];
         IW'(3): cur_byte = emit_addr_ff[15:8];
         IW'(4): cur_byte = emit_addr_ff[7:0];
         default: begin
            if (csum_hit) begin
               cur_byte = ~sum_ff;
            end else begin
               cur_byte = buffer_ff[data_idx[BW-1:0]];
            end
         end
      endcase
   end

   // Byte index and running sum
   always_comb begin
      idx_in = idx_ff;
      sum_in = sum_ff;
      if (cmd.load) begin
         idx_in = '0;
         sum_in = 8'd0;
      end else if (cmd.next_byte) begin
         idx_in = idx_ff + IW'(1);
         sum_in = sum_ff + cur_byte;
      end
   end

   always_ff @(posedge clock) begin
      kind7_ff     <= kind7_in;
      count_ff     <= count_in;
      emit_addr_ff <= emit_addr_in;
      emit_len_ff  <= emit_len_in;
      idx_ff       <= idx_in;
      sum_ff       <= sum_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_end_ff   <= rsp_end_in;
   end

   // Output register: load a character, hold while stalled
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_end_in   = rsp_end_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_end_in   = 1'b0;
         case (cmd.sel)
            CH_S:    rsp_char_in = CHAR_S;
            CH_KIND: rsp_char_in = kind7_ff ? CHAR_KIND7 : CHAR_KIND3;
            CH_HI:   rsp_char_in = hex_digit(cur_byte[7:4]);
            CH_LO:   rsp_char_in = hex_digit(cur_byte[3:0]);
            CH_NL: begin
               rsp_char_in = CHAR_NL;
               rsp_end_in  = 1'b1;
            end
            default: rsp_char_in = CHAR_NL;
         endcase
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ascii_char = rsp_char_ff;
   assign rsp_line_end   = rsp_end_ff;

endmodule

`default_nettype wire

// ===== rtl/srecord_s3_encoder.sv =====
// Top level of the S3 record encoder: controller plus datapath.
// Depends on srec_pkg, srec_ctrl and srec_dp.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  opcode, data_byte, range_first,
//                                            range_last, start_address
//   rsp      out        rsp_valid/rsp_stall  ascii_char, line_end
//   csr      in         csr_write            csr_index, csr_data
//
// An item that emits nothing is accepted while the controller stays idle. An
// item that emits a record is loaded, then its 2*n + 15 characters (n data
// bytes, n = 0 for S7) go out one a cycle through the output register while
// the output does not stall; intake stalls until the record is done.
// Reset is synchronous; it restores the register defaults and clears the
// fill count, addresses and entry state.
`default_nettype none

module srecord_s3_encoder
   import srec_pkg::*;
#(
   parameter int MAX_RECORD_BYTES = 16
)(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output      logic                      req_stall,
   input  wire logic [1:0]                req_opcode,
   input  wire logic [7:0]                req_data_byte,
   input  wire logic                      req_range_first,
   input  wire logic                      req_range_last,
   input  wire logic [31:0]               req_start_address,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   output      logic [6:0]                rsp_ascii_char,
   output      logic                      rsp_line_end,
   input  wire logic                      csr_write,
   input  wire logic                      csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   srec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   srec_dp #(
      .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_opcode        (req_opcode),
      .req_data_byte     (req_data_byte),
      .req_range_first   (req_range_first),
      .req_range_last    (req_range_last),
      .req_start_address (req_start_address),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_ascii_char    (rsp_ascii_char),
      .rsp_line_end      (rsp_line_end),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

`default_nettype wire

// ===== verif/srecord_s3_encoder_test.sv =====
// Self-checking testbench for srecord_s3_encoder: S3/S7 record text checked per character.
// Depends on srec_pkg and the srecord_s3_encoder RTL; predicts the text from its own encoder model.
`timescale 1ns / 1ps

module srecord_s3_encoder_test
   import srec_pkg::*;
();

   localparam int         BUF_DEPTH = 16;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  data_byte;
      logic        first;
      logic        last;
      logic [31:0] start;
   } enc_item_type;

   typedef struct packed {
      logic [6:0] ch;
      logic       line_end;
   } text_char_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   enc_item_type              cur_item = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [6:0]                rsp_ascii_char;
   logic                      rsp_line_end;
   logic                      csr_write = 1'b0;
   logic                      csr_index = 1'b0;
   logic [CSR_DATA_WIDTH-1:0] csr_data = '0;

   enc_item_type  items_to_send [$];
   text_char_type text_expected [$];
   int            taken_count = 0;
   int            used_count = 0;
   int            send_idle_pct = 0;
   int            recv_idle_pct = 0;
   int            hold_asked = 0;
   int            hold_served = 0;
   int            hold_left = 0;
   int            fail_count = 0;

   // Encoder model state
   logic [4:0]  cfg_max_bytes = MAX_BYTES_RESET;
   logic        cfg_entry_first = 1'b1;
   logic [7:0]  rec_buf [BUF_DEPTH];
   int          rec_fill = 0;
   logic [31:0] rec_addr = '0;
   logic [31:0] next_addr = '0;
   logic [31:0] entry_start = '0;
   logic        entry_ok = 1'b0;
   logic [7:0]  line_sum = '0;
   string       hex_chars = "0123456789ABCDEF";

   srecord_s3_encoder #(
      .MAX_RECORD_BYTES (BUF_DEPTH)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (cur_item.opcode),
      .req_data_byte     (cur_item.data_byte),
      .req_range_first   (cur_item.first),
      .req_range_last    (cur_item.last),
      .req_start_address (cur_item.start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ascii_char    (rsp_ascii_char),
      .rsp_line_end      (rsp_line_end),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------- encoder model ----------------

   task automatic put_text(input logic [6:0] c, input logic le);
      text_char_type t;
      t.ch = c;
      t.line_end = le;
      text_expected.push_back(t);
   endtask

   task automatic put_hex(input logic [7:0] b);
      put_text(7'(hex_chars[b[7:4]]), 1'b0);
      put_text(7'(hex_chars[b[3:0]]), 1'b0);
      line_sum = line_sum + b;
   endtask

   task automatic put_head(input logic [6:0] kind, input logic [7:0] count,
                           input logic [31:0] addr);
      line_sum = '0;
      put_text(CHAR_S, 1'b0);
      put_text(kind, 1'b0);
      put_hex(count);
      put_hex(addr[31:24]);
      put_hex(addr[23:16]);
      put_hex(addr[15:8]);
      put_hex(addr[7:0]);
   endtask

   // Checksum is the ones complement of the byte sum, then the newline
   task automatic put_tail();
      put_hex(~line_sum);
      put_text(CHAR_NL, 1'b1);
   endtask

   task automatic open_range(input logic [31:0] addr);
      rec_fill = 0;
      next_addr = addr;
      if (!entry_ok) begin
         entry_start = addr;
         entry_ok = 1'b1;
      end
   endtask

   task automatic predict_text(input enc_item_type it);
      int          limit;
      logic [31:0] entry;
      limit = (cfg_max_bytes == 0) ? 1 : ((cfg_max_bytes > BUF_DEPTH) ? BUF_DEPTH : cfg_max_bytes);
      case (it.opcode)
         OP_DATA: begin
            if (it.first) open_range(it.start);
            if (rec_fill == 0) rec_addr = next_addr;
            rec_buf[rec_fill] = it.data_byte;
            rec_fill++;
            next_addr = next_addr + 32'd1;
            // Emit when full or when the range closes
            if (rec_fill >= limit || it.last) begin
               put_head(CHAR_KIND3, COUNT_BASE + 8'(rec_fill), rec_addr);
               for (int i = 0; i < rec_fill; i++) put_hex(rec_buf[i]);
               put_tail();
               rec_fill = 0;
            end
         end
         OP_RANGE: open_range(it.start);
         OP_FINISH: begin
            entry = (cfg_entry_first && entry_ok) ? entry_start : 32'd0;
            put_head(CHAR_KIND7, COUNT_BASE, entry);
            put_tail();
            rec_fill = 0;
            rec_addr = '0;
            next_addr = '0;
            entry_start = '0;
            entry_ok = 1'b0;
         end
         default: ;
      endcase
   endtask

   // ---------------- driver ----------------

   // Note acceptance and predict the text it causes
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         predict_text(cur_item);
         taken_count++;
      end
   end

   // Offer the next item, or idle at random; hold a stalled item
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (taken_count != used_count || !req_valid) begin
         used_count = taken_count;
         if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            cur_item <= items_to_send.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall the text channel at random, or for a long stretch on request
   always @(negedge clock) begin
      if (hold_asked != hold_served) begin
         hold_served = hold_asked;
         hold_left = 300;
      end
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // ---------------- monitor ----------------

   always @(posedge clock) begin : watch_text
      text_char_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (text_expected.size() == 0) begin
            $display("%0t: unexpected char: expected none, actual %h line_end %b",
                     $time, rsp_ascii_char, rsp_line_end);
            fail_count++;
         end else begin
            want = text_expected.pop_front();
            if (want.ch != rsp_ascii_char) begin
               $display("%0t: ascii_char mismatch: expected %h, actual %h",
                        $time, want.ch, rsp_ascii_char);
               fail_count++;
            end
            if (want.line_end != rsp_line_end) begin
               $display("%0t: line_end mismatch: expected %b, actual %b",
                        $time, want.line_end, rsp_line_end);
               fail_count++;
            end
         end
      end
   end

   // ---------------- stimulus ----------------

   function automatic enc_item_type make_item(input logic [1:0] op, input logic [7:0] b,
                                              input logic f, input logic l,
                                              input logic [31:0] a);
      enc_item_type it;
      it.opcode = op;
      it.data_byte = b;
      it.first = f;
      it.last = l;
      it.start = a;
      return it;
   endfunction

   // Wait until all items went in and all text came out, then let the block settle
   task automatic drain();
      while (items_to_send.size() != 0 || req_valid || text_expected.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_MAX_RECORD_BYTES) cfg_max_bytes = value;
      else cfg_entry_first = value[0];
   endtask

   // Mostly well-formed ranges with random content, plus broken and stray items
   task automatic queue_random(input int want);
      int          made;
      int          kind;
      int          len;
      logic [31:0] base;
      made = 0;
      while (made < want) begin
         kind = $urandom_range(99);
         base = ($urandom_range(4) == 0) ? 32'hFFFF_FFF0 + $urandom_range(15) : $urandom();
         len = ($urandom_range(6) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
         if (kind < 70) begin
            for (int k = 0; k < len; k++)
               items_to_send.push_back(make_item(OP_DATA, 8'($urandom()), k == 0,
                                                 k == len - 1,
                                                 (k == 0) ? base : $urandom()));
            made += len;
         end else if (kind < 80) begin
            items_to_send.push_back(make_item(OP_RANGE, 8'($urandom()), 1'($urandom()),
                                              1'($urandom()), base));
            for (int k = 0; k < len; k++)
               items_to_send.push_back(make_item(OP_DATA, 8'($urandom()), 1'b0,
                                                 k == len - 1, $urandom()));
            made += len + 1;
         end else if (kind < 88) begin
            // range left open: dropped or continued by what follows
            for (int k = 0; k < len; k++)
               items_to_send.push_back(make_item(OP_DATA, 8'($urandom()), k == 0, 1'b0,
                                                 (k == 0) ? base : $urandom()));
            made += len;
         end else if (kind < 94) begin
            items_to_send.push_back(make_item(OP_FINISH, 8'($urandom()), 1'($urandom()),
                                              1'($urandom()), $urandom()));
            made++;
         end else if (kind < 97) begin
            items_to_send.push_back(make_item(OP_UNUSED, 8'($urandom()), 1'($urandom()),
                                              1'($urandom()), $urandom()));
         end else begin
            items_to_send.push_back(make_item(OP_DATA, 8'($urandom()), 1'($urandom()),
                                              1'($urandom()), $urandom()));
            made++;
         end
      end
   endtask

   task automatic run_phase(input logic [4:0] max_bytes, input logic entry_first,
                            input int send_pct, input int recv_pct, input logic hold);
      write_csr(CSR_MAX_RECORD_BYTES, max_bytes);
      write_csr(CSR_ENTRY_FROM_FIRST, CSR_DATA_WIDTH'(entry_first));
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      if (hold) hold_asked++;
      queue_random(13);
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 8;
      recv_idle_pct = 58;

      // Directed part at reset settings
      items_to_send.push_back(make_item(OP_UNUSED, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF));
      items_to_send.push_back(make_item(OP_RANGE, 8'h00, 1'b0, 1'b0, 32'hFFFF_FFFE));
      // bytes without range_first continue and wrap past the top address
      items_to_send.push_back(make_item(OP_DATA, 8'h00, 1'b0, 1'b0, 32'h0));
      items_to_send.push_back(make_item(OP_DATA, 8'hFF, 1'b0, 1'b0, 32'hFFFF_FFFF));
      items_to_send.push_back(make_item(OP_DATA, 8'h80, 1'b0, 1'b1, 32'h0));
      items_to_send.push_back(make_item(OP_DATA, 8'h5A, 1'b1, 1'b1, 32'h0000_0000));
      // open record dropped by a new range_first
      items_to_send.push_back(make_item(OP_DATA, 8'h11, 1'b1, 1'b0, 32'hDEAD_BEEF));
      items_to_send.push_back(make_item(OP_DATA, 8'h22, 1'b0, 1'b0, 32'h0));
      items_to_send.push_back(make_item(OP_DATA, 8'h33, 1'b1, 1'b1, 32'h0001_0000));
      // open record dropped by an empty range start
      items_to_send.push_back(make_item(OP_DATA, 8'h44, 1'b1, 1'b0, 32'h0000_0100));
      items_to_send.push_back(make_item(OP_RANGE, 8'hAA, 1'b1, 1'b1, 32'h0000_0200));
      items_to_send.push_back(make_item(OP_DATA, 8'h55, 1'b0, 1'b1, 32'hFFFF_FFFF));
      // open record dropped by a finish, then a finish with no entry
      items_to_send.push_back(make_item(OP_DATA, 8'h66, 1'b1, 1'b0, 32'h0000_0300));
      items_to_send.push_back(make_item(OP_FINISH, 8'h00, 1'b0, 1'b0, 32'h0));
      items_to_send.push_back(make_item(OP_FINISH, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF));
      // byte with no range at all after a finish
      items_to_send.push_back(make_item(OP_DATA, 8'h77, 1'b0, 1'b1, 32'h1234_5678));
      drain();

      run_phase(5'd0,  1'b1, 8,  58, 1'b0);
      run_phase(5'd1,  1'b0, 8,  58, 1'b1);
      run_phase(5'd24, 1'b1, 58, 8,  1'b0);
      run_phase(5'd31, 1'b0, 58, 8,  1'b0);
      run_phase(5'd16, 1'b1, 0,  0,  1'b0);
      run_phase(5'd5,  1'b1, 0,  0,  1'b0);

      if (fail_count == 0) begin
         $display("srecord_s3_encoder_test passed");
      end else begin
         $display("srecord_s3_encoder_test failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("srecord_s3_encoder_test failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/srec_pkg.sv
rtl/srec_ctrl.sv
rtl/srec_dp.sv
rtl/srecord_s3_encoder.sv
verif/srecord_s3_encoder_test.sv
